/* rtl/core/dxtvf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtvf_pkg
// Shared types and constants of the DXT surface vertical flip block.
// ----------------------------------------------------------------------------
package dxtvf_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIM_W       = 13;
    localparam int TOTAL_W     = 2 * DIM_W;
    localparam int MAX_DIM     = 4096;
    localparam int DATA_W      = 64;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_DXT1 = 2'd1,
        MODE_DXT3 = 2'd2,
        MODE_DXT5 = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EARLY    = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_MODE        = 2'd0,
        CFG_LINE_LENGTH = 2'd1,
        CFG_LINE_COUNT  = 2'd2,
        CFG_SLICE_COUNT = 2'd3
    } t_cfg_index;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } t_command;

    // store access and result flags from the sequencer for one word
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic              result;
        t_status           status;
        logic              eol;
        logic              eos;
    } t_access;

endpackage
`default_nettype wire

/* rtl/core/dxtvf_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtvf_store
// Single port slice store, 128-bit entries, registered read data.
// ----------------------------------------------------------------------------
module dxtvf_store import dxtvf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic                  i_re,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [2*DATA_W-1:0]   i_wdata,
    output logic      [2*DATA_W-1:0]   o_rdata
);

    logic [2*DATA_W-1:0] mem [STORE_DEPTH];
    logic [2*DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/core/dxtvf_flip.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtvf_flip
// Fixed bit permutation that flips one DXT block upside down; raw words pass unchanged.
// ----------------------------------------------------------------------------
module dxtvf_flip import dxtvf_pkg::*; (
    input  wire t_mode             i_mode,
    input  wire logic [DATA_W-1:0] i_low,
    input  wire logic [DATA_W-1:0] i_high,
    output logic      [DATA_W-1:0] o_low,
    output logic      [DATA_W-1:0] o_high
);

    // endpoints kept, four index row bytes reversed
    function automatic logic [DATA_W-1:0] flip_colour(input logic [DATA_W-1:0] b);
        flip_colour = {b[39:32], b[47:40], b[55:48], b[63:56], b[31:0]};
    endfunction

    // four 16-bit alpha rows reversed
    function automatic logic [DATA_W-1:0] flip_explicit(input logic [DATA_W-1:0] b);
        flip_explicit = {b[15:0], b[31:16], b[47:32], b[63:48]};
    endfunction

    // two endpoints kept, four 12-bit index rows reversed
    function automatic logic [DATA_W-1:0] flip_interp(input logic [DATA_W-1:0] b);
        flip_interp = {b[27:16], b[39:28], b[51:40], b[63:52], b[15:0]};
    endfunction

    always_comb begin
        unique case (i_mode)
            MODE_DXT1: begin
                o_low  = flip_colour(i_low);
                o_high = '0;
            end
            MODE_DXT3: begin
                o_low  = flip_explicit(i_low);
                o_high = flip_colour(i_high);
            end
            MODE_DXT5: begin
                o_low  = flip_interp(i_low);
                o_high = flip_colour(i_high);
            end
            default: begin
                o_low  = i_low;
                o_high = i_high;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/dxtvf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxtvf_ctrl
// Configuration registers and the load / fetch address sequencer.
// ----------------------------------------------------------------------------
module dxtvf_ctrl import dxtvf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_step,
    input  wire logic                  i_command,
    output t_mode                      o_mode,
    output t_access                    o_acc
);

    t_mode             r_mode;
    logic [DIM_W-1:0]  r_line_length;
    logic [DIM_W-1:0]  r_line_count;
    logic [11:0]       r_slice_count;
    logic [CNT_W-1:0]  r_loaded_count;
    logic [11:0]       r_out_line;
    logic [11:0]       r_out_column;
    logic [10:0]       r_slice_index;
    logic [ADDR_W-1:0] r_line_off;

    logic [DIM_W-1:0]   len;
    logic [DIM_W-1:0]   cnt;
    logic [11:0]        slices;
    logic [11:0]        slice_inc;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] rd_addr_full;
    logic               oversize;
    logic               loaded_full;
    logic               eol;
    logic               eos;
    logic               is_fetch;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            clamp_dim = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            clamp_dim = DIM_W'(MAX_DIM);
        end else begin
            clamp_dim = v;
        end
    endfunction

    assign len       = clamp_dim(r_line_length);
    assign cnt       = clamp_dim(r_line_count);
    assign slices    = (r_slice_count == '0) ? 12'd1 : r_slice_count;
    assign slice_inc = {1'b0, r_slice_index} + 12'd1;
    assign total     = TOTAL_W'(len) * TOTAL_W'(cnt);
    assign oversize  = total > TOTAL_W'(STORE_DEPTH);
    assign loaded_full = TOTAL_W'(r_loaded_count) >= total;
    assign eol = {1'b0, r_out_column} == (len - DIM_W'(1));
    assign eos = eol && ({1'b0, r_out_line} == (cnt - DIM_W'(1)));
    assign is_fetch = (i_command == CMD_FETCH);

    // last line starts at total - len, each finished line moves one line up
    assign rd_addr_full = total - TOTAL_W'(len) - TOTAL_W'(r_line_off)
                        + TOTAL_W'(r_out_column);

    always_comb begin
        o_acc.we     = i_step && !is_fetch && !oversize && !loaded_full;
        o_acc.re     = i_step && is_fetch && !oversize && loaded_full;
        o_acc.addr   = o_acc.we ? r_loaded_count[ADDR_W-1:0]
                                : rd_addr_full[ADDR_W-1:0];
        o_acc.result = i_step && (oversize || is_fetch);
        o_acc.eol    = eol;
        o_acc.eos    = eos;
        priority if (oversize) begin
            o_acc.status = ST_OVERSIZE;
        end else if (!loaded_full) begin
            o_acc.status = ST_EARLY;
        end else begin
            o_acc.status = ST_OK;
        end
    end

    assign o_mode = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RAW;
            r_line_length  <= DIM_W'(1);
            r_line_count   <= DIM_W'(1);
            r_slice_count  <= 12'd1;
            r_loaded_count <= '0;
            r_out_line     <= '0;
            r_out_column   <= '0;
            r_slice_index  <= '0;
            r_line_off     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE:        r_mode        <= t_mode'(i_cfg_data[1:0]);
                CFG_LINE_LENGTH: r_line_length <= i_cfg_data[DIM_W-1:0];
                CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[DIM_W-1:0];
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[11:0];
                default: ;
            endcase
            // any register write restarts the surface
            r_loaded_count <= '0;
            r_out_line     <= '0;
            r_out_column   <= '0;
            r_slice_index  <= '0;
            r_line_off     <= '0;
        end else if (o_acc.we) begin
            r_loaded_count <= r_loaded_count + CNT_W'(1);
        end else if (o_acc.re) begin
            if (eos) begin
                r_loaded_count <= '0;
                r_out_line     <= '0;
                r_out_column   <= '0;
                r_line_off     <= '0;
                r_slice_index  <= (slice_inc >= slices) ? '0 : slice_inc[10:0];
            end else if (eol) begin
                r_out_column <= '0;
                r_out_line   <= r_out_line + 12'd1;
                r_line_off   <= ADDR_W'(TOTAL_W'(r_line_off) + TOTAL_W'(len));
            end else begin
                r_out_column <= r_out_column + 12'd1;
            end
        end
    end

    a_read_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_acc.re |-> (o_acc.status == ST_OK && !o_acc.we))
        else $error("store read issued before slice complete");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !oversize |-> (TOTAL_W'(r_loaded_count) <= total))
        else $error("fill count beyond slice size");

    a_slice_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_slice_index} < slices) || $past(i_cfg_valid))
        else $error("slice index out of range");

endmodule
`default_nettype wire

/* rtl/core/dxt_surface_vertical_flip_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_surface_vertical_flip_top
// Vertical flip of a texture surface slice by slice, raw bytes or DXT blocks.
// ----------------------------------------------------------------------------
// a result or error word passes the store read stage, then the flip and output register
// throughput: one load or fetch word per cycle, set by the single store port, while
//   the output is not stalled and no register write is made
// reset: synchronous, clears configuration to defaults and all counters;
//   store contents are not cleared, only entries loaded in the current slice are read
module dxt_surface_vertical_flip_top import dxtvf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [DATA_W-1:0]     i_data_low,
    input  wire logic [DATA_W-1:0]     i_data_high,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [DATA_W-1:0]     o_flipped_low,
    output logic      [DATA_W-1:0]     o_flipped_high,
    output logic                       o_last_of_line,
    output logic                       o_last_of_slice,
    output logic      [1:0]            o_status
);

    t_mode   mode;
    t_access acc;
    logic    step;
    logic    out_load;

    logic [DATA_W-1:0]   wr_low;
    logic [DATA_W-1:0]   wr_high;
    logic [2*DATA_W-1:0] rd_data;
    logic [DATA_W-1:0]   fl_low;
    logic [DATA_W-1:0]   fl_high;

    logic        r_s1_valid;
    t_status     r_s1_status;
    logic        r_s1_eol;
    logic        r_s1_eos;
    logic        r_out_valid;
    logic [DATA_W-1:0] r_out_low;
    logic [DATA_W-1:0] r_out_high;
    logic        r_out_eol;
    logic        r_out_eos;
    t_status     r_out_status;

    assign o_cfg_ready = 1'b1;
    assign out_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    // a register write takes the cycle, no data word is taken beside it
    assign o_in_ready  = (!r_s1_valid || out_load) && !i_cfg_valid;
    assign step        = i_in_valid && o_in_ready;

    // drop the bytes the mode does not use
    always_comb begin
        unique case (mode)
            MODE_RAW: begin
                wr_low  = {{(DATA_W-8){1'b0}}, i_data_low[7:0]};
                wr_high = '0;
            end
            MODE_DXT1: begin
                wr_low  = i_data_low;
                wr_high = '0;
            end
            default: begin
                wr_low  = i_data_low;
                wr_high = i_data_high;
            end
        endcase
    end

    dxtvf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_command   (i_command),
        .o_mode      (mode),
        .o_acc       (acc)
    );

    dxtvf_store u_store (
        .i_clk   (i_clk),
        .i_we    (acc.we),
        .i_re    (acc.re),
        .i_addr  (acc.addr),
        .i_wdata ({wr_high, wr_low}),
        .o_rdata (rd_data)
    );

    dxtvf_flip u_flip (
        .i_mode (mode),
        .i_low  (rd_data[DATA_W-1:0]),
        .i_high (rd_data[2*DATA_W-1:DATA_W]),
        .o_low  (fl_low),
        .o_high (fl_high)
    );

    // read stage: flags wait here for the store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (step && acc.result) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && acc.result) begin
            r_s1_status <= acc.status;
            r_s1_eol    <= acc.eol;
            r_s1_eos    <= acc.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // error words carry zero data and flags
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_s1_status;
            if (r_s1_status == ST_OK) begin
                r_out_low  <= fl_low;
                r_out_high <= fl_high;
                r_out_eol  <= r_s1_eol;
                r_out_eos  <= r_s1_eos;
            end else begin
                r_out_low  <= '0;
                r_out_high <= '0;
                r_out_eol  <= 1'b0;
                r_out_eos  <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_flipped_low   = r_out_low;
    assign o_flipped_high  = r_out_high;
    assign o_last_of_line  = r_out_eol;
    assign o_last_of_slice = r_out_eos;
    assign o_status        = r_out_status;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
        (r_out_low == '0 && r_out_high == '0 && !r_out_eol && !r_out_eos))
        else $error("error word carries data");

    a_eos_has_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eos) |-> r_out_eol)
        else $error("end of slice without end of line");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are stalled");

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("read stage did not move to output");

endmodule
`default_nettype wire
